@@ hdl/percolation_site_labeler_macros.svh @@
// ----------------------------------------------------------------------------
// percolation_site_labeler_macros.svh
// Assertion macros used by the percolation site labeler checker.
// ----------------------------------------------------------------------------
`ifndef PERCOLATION_SITE_LABELER_MACROS_SVH
`define PERCOLATION_SITE_LABELER_MACROS_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define PSL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define PSL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/psl_pkg.sv @@
// ----------------------------------------------------------------------------
// psl_pkg
// Types and constants of the percolation site labeler.
// ----------------------------------------------------------------------------
package psl_pkg;

    // fixed field widths
    localparam int COORD_W = 6;
    localparam int COUNT_W = 13;

    // input transfer payload
    typedef struct packed {
        logic [COORD_W-1:0] site_row;
        logic [COORD_W-1:0] site_col;
    } t_psl_in;

    // output transfer payload
    typedef struct packed {
        logic               percolates;
        logic [COUNT_W-1:0] open_sites;
        logic [COUNT_W-1:0] site_label;
    } t_psl_out;

    // sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADDR,
        ST_SELF_RD,
        ST_SELF_CHK,
        ST_NB_RD,
        ST_NB_CHK,
        ST_SWEEP,
        ST_DONE
    } t_psl_state;

    // neighbour order
    typedef enum logic [1:0] {
        DIR_UP,
        DIR_DOWN,
        DIR_LEFT,
        DIR_RIGHT
    } t_psl_dir;

endpackage

@@ hdl/psl_label_ram.sv @@
// ----------------------------------------------------------------------------
// psl_label_ram
// Label store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module psl_label_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int LW    = 13
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [LW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [LW-1:0] o_rd_data
);

    logic [LW-1:0] mem [DEPTH];
    logic [LW-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/psl_label_cmp.sv @@
// ----------------------------------------------------------------------------
// psl_label_cmp
// Shared label compare unit: minimum search and relabel match.
// ----------------------------------------------------------------------------
module psl_label_cmp #(
    parameter int LW = 13
) (
    input  logic [LW-1:0]       i_label,
    input  logic [LW-1:0]       i_best,
    input  logic [3:0][LW-1:0]  i_nb,
    output logic                o_lower,
    output logic                o_hit
);

    // open label below the running minimum
    assign o_lower = (i_label != '0) && (i_label < i_best);

    // label belongs to one of the merged components
    always_comb begin
        o_hit = 1'b0;
        for (int k = 0; k < 4; k++) begin
            if ((i_nb[k] != '0) && (i_label == i_nb[k])) begin
                o_hit = 1'b1;
            end
        end
    end

endmodule

@@ hdl/percolation_site_labeler.sv @@
// ----------------------------------------------------------------------------
// percolation_site_labeler
// Opens grid sites one at a time and keeps quick-find component labels.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all GRID_SIDE*GRID_SIDE
// cells of the label memory (4096 at the default), one cell per cycle, with
// o_in_ready low. Each opened site then takes one input transfer and gives one
// output transfer. For a newly opened site the relabel pass sweeps the whole
// label memory through its single read port, one cell per cycle, after the
// four neighbour reads. Reopening an open site skips the neighbour reads and
// the sweep, and a site outside the grid goes straight to the result. The next
// input is taken once the block is back in idle and the output register is
// empty or being drained.
module percolation_site_labeler import psl_pkg::*; #(
    parameter int GRID_SIDE = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_psl_in  i_in,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_psl_out o_out
);

    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int LW    = $clog2(CELLS + 1);
    localparam int RW    = $clog2(GRID_SIDE);
    localparam int CW    = AW + 1;

    localparam logic [CW-1:0] CELLS_C     = CW'(CELLS);
    localparam logic [AW-1:0] LAST_ADDR   = AW'(CELLS - 1);
    localparam logic [AW-1:0] BOTTOM_ADDR = AW'(CELLS - GRID_SIDE);
    localparam logic [AW-1:0] SIDE_A      = AW'(GRID_SIDE);
    localparam logic [RW-1:0] EDGE_RC     = RW'(GRID_SIDE - 1);
    localparam logic [8:0]    SIDE_C      = 9'(GRID_SIDE);

    t_psl_state r_state, n_state;

    logic [COORD_W-1:0]   r_row_raw, r_col_raw;
    logic [AW-1:0]        r_idx;
    logic [LW-1:0]        r_best;
    logic [LW-1:0]        r_lab;
    logic [3:0][LW-1:0]   r_nb;
    t_psl_dir             r_k;
    logic [CW-1:0]        r_cnt;
    logic                 r_sw_vld;
    logic [AW-1:0]        r_sw_addr;
    logic                 r_sw_perc;
    logic                 r_perc;
    logic [COUNT_W-1:0]   r_open;
    logic                 r_out_vld;
    t_psl_out             r_out;

    logic [RW-1:0] row, col;
    logic          in_range;
    logic          nb_ok;
    logic [AW-1:0] nb_addr;
    logic [LW-1:0] best_init;
    logic [LW-1:0] cmp_label;
    logic [LW-1:0] sw_new;
    logic          cnt_live;
    logic          sweep_last;
    logic          sw_perc_hit;
    logic          lower, hit;
    logic          in_xfer;

    logic          ram_wr_en, ram_rd_en;
    logic [AW-1:0] ram_wr_addr, ram_rd_addr;
    logic [LW-1:0] ram_wr_data, ram_rd_data;

    // label memory
    psl_label_ram #(
        .DEPTH (CELLS),
        .AW    (AW),
        .LW    (LW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // shared compare unit
    psl_label_cmp #(
        .LW (LW)
    ) u_cmp (
        .i_label (cmp_label),
        .i_best  (r_best),
        .i_nb    (r_nb),
        .o_lower (lower),
        .o_hit   (hit)
    );

    // site coordinates and range check
    assign row      = RW'(r_row_raw);
    assign col      = RW'(r_col_raw);
    assign in_range = ({3'b000, r_row_raw} < SIDE_C) && ({3'b000, r_col_raw} < SIDE_C);
    assign best_init = (row == '0) ? LW'(1) : (LW'(r_idx) + LW'(1));

    // neighbour address and border check
    always_comb begin
        case (r_k)
            DIR_UP: begin
                nb_ok   = (row != '0);
                nb_addr = r_idx - SIDE_A;
            end
            DIR_DOWN: begin
                nb_ok   = (row != EDGE_RC);
                nb_addr = r_idx + SIDE_A;
            end
            DIR_LEFT: begin
                nb_ok   = (col != '0);
                nb_addr = r_idx - AW'(1);
            end
            DIR_RIGHT: begin
                nb_ok   = (col != EDGE_RC);
                nb_addr = r_idx + AW'(1);
            end
            default: begin
                nb_ok   = 1'b0;
                nb_addr = r_idx;
            end
        endcase
    end

    // compare operand: closed when the neighbour lies off the grid
    assign cmp_label = ((r_state == ST_NB_CHK) && !nb_ok) ? '0 : ram_rd_data;

    // relabel sweep
    assign cnt_live    = (r_cnt < CELLS_C);
    assign sweep_last  = r_sw_vld && (r_sw_addr == LAST_ADDR);
    assign sw_new      = ((r_sw_addr == r_idx) || hit) ? r_best : ram_rd_data;
    assign sw_perc_hit = r_sw_vld && (r_sw_addr >= BOTTOM_ADDR) && (sw_new == LW'(1));

    assign in_xfer = i_in_valid && o_in_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_cnt[AW-1:0] == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = ST_ADDR;
                end
            end
            ST_ADDR: begin
                n_state = in_range ? ST_SELF_RD : ST_DONE;
            end
            ST_SELF_RD: begin
                n_state = ST_SELF_CHK;
            end
            ST_SELF_CHK: begin
                n_state = (ram_rd_data != '0) ? ST_DONE : ST_NB_RD;
            end
            ST_NB_RD: begin
                n_state = ST_NB_CHK;
            end
            ST_NB_CHK: begin
                n_state = (r_k == DIR_RIGHT) ? ST_SWEEP : ST_NB_RD;
            end
            ST_SWEEP: begin
                if (sweep_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // memory control and handshake outputs
    always_comb begin
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_idx;
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_sw_addr;
        ram_wr_data = sw_new;
        o_in_ready  = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_cnt[AW-1:0];
                ram_wr_data = '0;
            end
            ST_IDLE: begin
                o_in_ready = !r_out_vld || i_out_ready;
            end
            ST_SELF_RD: begin
                ram_rd_en = 1'b1;
            end
            ST_NB_RD: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = nb_addr;
            end
            ST_SWEEP: begin
                ram_rd_en   = cnt_live;
                ram_rd_addr = r_cnt[AW-1:0];
                ram_wr_en   = r_sw_vld;
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_cnt     <= '0;
            r_sw_vld  <= 1'b0;
            r_perc    <= 1'b0;
            r_open    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;

            // output register: loads at the end of an item, drains on transfer
            if (r_state == ST_DONE) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                ST_CLEAR: begin
                    r_cnt <= r_cnt + CW'(1);
                end
                ST_NB_CHK: begin
                    if (r_k == DIR_RIGHT) begin
                        r_cnt    <= '0;
                        r_sw_vld <= 1'b0;
                    end
                end
                ST_SWEEP: begin
                    if (cnt_live) begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                    r_sw_vld <= cnt_live;
                    if (sweep_last) begin
                        r_perc <= r_sw_perc || sw_perc_hit;
                        r_open <= r_open + COUNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    r_row_raw <= i_in.site_row;
                    r_col_raw <= i_in.site_col;
                end
            end
            ST_ADDR: begin
                r_idx <= AW'(AW'(row) * SIDE_A) + AW'(col);
                r_lab <= '0;
            end
            ST_SELF_CHK: begin
                r_lab  <= ram_rd_data;
                r_best <= best_init;
                r_k    <= DIR_UP;
            end
            ST_NB_CHK: begin
                r_nb[r_k] <= cmp_label;
                if (lower) begin
                    r_best <= cmp_label;
                end
                r_k <= t_psl_dir'(r_k + 2'd1);
                if (r_k == DIR_RIGHT) begin
                    r_sw_perc <= 1'b0;
                end
            end
            ST_SWEEP: begin
                r_sw_addr <= r_cnt[AW-1:0];
                r_sw_perc <= r_sw_perc || sw_perc_hit;
                if (sweep_last) begin
                    r_lab <= r_best;
                end
            end
            ST_DONE: begin
                r_out.percolates <= r_perc;
                r_out.open_sites <= r_open;
                r_out.site_label <= COUNT_W'(r_lab);
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule

@@ hdl/psl_checker.sv @@
// ----------------------------------------------------------------------------
// psl_checker
// Port-level checks of the percolation site labeler, bound to the top level.
// ----------------------------------------------------------------------------
`include "percolation_site_labeler_macros.svh"

module psl_checker import psl_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_ready,
    input  logic     i_out_valid,
    input  logic     i_out_ready,
    input  t_psl_out i_out
);

    // a new item is only taken when the output register is empty or being drained
    `PSL_ASSERT_NOW(a_ready_needs_room, i_in_ready, (!i_out_valid || i_out_ready), "input ready while result blocked")

    // one item at a time: ready drops after an input transfer
    `PSL_ASSERT_NEXT(a_one_item, (i_in_valid && i_in_ready), !i_in_ready, "second item taken back to back")

    // a result never appears in the cycle after an input transfer
    `PSL_ASSERT_NEXT(a_no_instant_result, (i_in_valid && i_in_ready), !i_out_valid, "result too early")

    // a stalled result holds
    `PSL_ASSERT_NEXT(a_out_hold, (i_out_valid && !i_out_ready), (i_out_valid && $stable(i_out)), "stalled result changed")

endmodule

bind percolation_site_labeler psl_checker u_psl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out       (o_out)
);

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the percolation site labeler.
// ----------------------------------------------------------------------------
// A directed table opens corners, borders, isolated sites, merges and
// reopens, and fixes a few results by hand. A random part follows. Most of
// it is a walk from the top row down that runs until it reaches the bottom
// row, so the grid percolates. The rest opens neighbours of open sites,
// reopens sites and opens sites anywhere. Every result not fixed by hand is
// checked against a label grid kept by the bench. Sender idling and receiver
// stalls change from phase to phase.
// ----------------------------------------------------------------------------
module tb_top;
    import psl_pkg::*;

    localparam int GRID_SIDE    = 64;
    localparam int CELLS        = GRID_SIDE * GRID_SIDE;
    localparam int RAND_SITES   = 100;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int DRAIN_CYCLES = 40;

    // one row of the directed table
    typedef struct {
        t_psl_in  site;
        bit       typed;
        t_psl_out want;
    } t_site_row;

    logic     i_clk     = 1'b0;
    logic     i_rst_n   = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    t_psl_in  in_site   = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    t_psl_out out_status;

    // bench copy of the label grid
    int unsigned site_lbl [CELLS];
    int unsigned open_count;
    t_psl_in     open_list [$];

    t_psl_out    status_q [$];
    t_site_row   directed_q [$];
    t_psl_out    want_status;

    int stall_pct;
    int send_idle_pct;
    int error_count;
    int results_seen;
    int sites_sent;
    int cycle_count;
    bit perc_seen;

    // downward walk that builds a top to bottom path
    int walk_row;
    int walk_col;
    bit walk_reached;

    percolation_site_labeler #(
        .GRID_SIDE (GRID_SIDE)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_site),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_status)
    );

    // clock
    always #10 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        if (error_count < 30) begin
            $display("[%0t] %s", $time, msg);
        end
        error_count++;
    endtask

    // open one site, merge neighbour labels, return the status it reports
    function automatic t_psl_out open_site(input t_psl_in s);
        int unsigned r;
        int unsigned c;
        int unsigned idx;
        int unsigned best;
        int unsigned nb [4];
        t_psl_out    res;
        r   = s.site_row;
        c   = s.site_col;
        idx = r * GRID_SIDE + c;
        if (site_lbl[idx] == 0) begin
            best = (r == 0) ? 1 : idx + 1;
            nb[DIR_UP]    = (r > 0) ? site_lbl[idx - GRID_SIDE] : 0;
            nb[DIR_DOWN]  = (r + 1 < GRID_SIDE) ? site_lbl[idx + GRID_SIDE] : 0;
            nb[DIR_LEFT]  = (c > 0) ? site_lbl[idx - 1] : 0;
            nb[DIR_RIGHT] = (c + 1 < GRID_SIDE) ? site_lbl[idx + 1] : 0;
            for (int k = 0; k < 4; k++) begin
                if (nb[k] != 0 && nb[k] < best) best = nb[k];
            end
            site_lbl[idx] = best;
            // neighbour labels as read before any relabel
            for (int k = 0; k < 4; k++) begin
                if (nb[k] != 0) begin
                    for (int i = 0; i < CELLS; i++) begin
                        if (site_lbl[i] == nb[k]) site_lbl[i] = best;
                    end
                end
            end
            open_count++;
            open_list.push_back(s);
        end
        res.percolates = 1'b0;
        for (int col = 0; col < GRID_SIDE; col++) begin
            if (site_lbl[(GRID_SIDE - 1) * GRID_SIDE + col] == 1) res.percolates = 1'b1;
        end
        res.open_sites = COUNT_W'(open_count);
        res.site_label = COUNT_W'(site_lbl[idx]);
        return res;
    endfunction

    // random site: mostly the walk, then neighbours, reopens and noise
    function automatic t_psl_in next_site();
        int       pick;
        int       r;
        int       c;
        t_psl_in  o;
        t_psl_dir d;
        pick = $urandom_range(99);
        if (pick < 70 || open_list.size() == 0) begin
            r = walk_row;
            c = walk_col;
            if (walk_row == GRID_SIDE - 1) begin
                walk_reached = 1'b1;
                walk_row     = 0;
                walk_col     = $urandom_range(GRID_SIDE - 1);
            end else if ($urandom_range(9) == 0) begin
                if (walk_col == 0) walk_col = 1;
                else if (walk_col == GRID_SIDE - 1) walk_col = walk_col - 1;
                else walk_col = $urandom_range(1) ? walk_col + 1 : walk_col - 1;
            end else begin
                walk_row++;
            end
        end else if (pick < 92) begin
            o = open_list[$urandom_range(open_list.size() - 1)];
            r = o.site_row;
            c = o.site_col;
            // neighbour of an open site, falls back to a reopen at the border
            if (pick < 85) begin
                d = t_psl_dir'($urandom_range(3));
                case (d)
                    DIR_UP:    if (r > 0) r--;
                    DIR_DOWN:  if (r < GRID_SIDE - 1) r++;
                    DIR_LEFT:  if (c > 0) c--;
                    default:   if (c < GRID_SIDE - 1) c++;
                endcase
            end
        end else begin
            r = $urandom_range(GRID_SIDE - 1);
            c = $urandom_range(GRID_SIDE - 1);
        end
        o.site_row = COORD_W'(r);
        o.site_col = COORD_W'(c);
        return o;
    endfunction

    function automatic void add_row(input int r, input int c, input bit typed,
                                    input bit perc, input int opened, input int lbl);
        t_site_row row;
        row.site.site_row  = COORD_W'(r);
        row.site.site_col  = COORD_W'(c);
        row.typed          = typed;
        row.want.percolates = perc;
        row.want.open_sites = COUNT_W'(opened);
        row.want.site_label = COUNT_W'(lbl);
        directed_q.push_back(row);
    endfunction

    // drive one site and wait for its input transfer
    task automatic push_site(input t_psl_in s, input bit typed, input t_psl_out want);
        t_psl_out pred;
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_site  <= s;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        pred = open_site(s);
        status_q.push_back(typed ? want : pred);
        sites_sent++;
    endtask

    // receiver stalls
    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // output transfer check
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            results_seen++;
            if (status_q.size() == 0) begin
                report_mismatch("output transfer with no pending open");
            end else begin
                want_status = status_q.pop_front();
                if (out_status.percolates !== want_status.percolates)
                    report_mismatch($sformatf("percolates got %0b want %0b",
                        out_status.percolates, want_status.percolates));
                if (out_status.open_sites !== want_status.open_sites)
                    report_mismatch($sformatf("open_sites got %0d want %0d",
                        out_status.open_sites, want_status.open_sites));
                if (out_status.site_label !== want_status.site_label)
                    report_mismatch($sformatf("site_label got %0d want %0d",
                        out_status.site_label, want_status.site_label));
                if (want_status.percolates) perc_seen = 1'b1;
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("run limit of %0d cycles hit, %0d results pending",
                CYCLE_LIMIT, status_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        t_site_row row;
        t_psl_out  none;
        int        n;
        none          = '0;
        stall_pct     = 0;
        send_idle_pct = 0;
        walk_row      = 0;
        walk_col      = $urandom_range(GRID_SIDE - 1);

        // corners, reopen, borders, isolated sites, merges, alternating bits
        add_row( 0,  0, 1, 0, 1, 1);
        add_row( 0,  0, 1, 0, 1, 1);
        add_row(63, 63, 1, 0, 2, 4096);
        add_row(63,  0, 1, 0, 3, 4033);
        add_row( 0, 63, 1, 0, 4, 1);
        add_row(62, 63, 0, 0, 0, 0);
        add_row( 1,  0, 0, 0, 0, 0);
        add_row( 0,  1, 0, 0, 0, 0);
        add_row(32, 32, 1, 0, 8, 2081);
        add_row(32, 33, 0, 0, 0, 0);
        add_row(31, 33, 0, 0, 0, 0);
        add_row(30, 32, 0, 0, 0, 0);
        add_row(31, 32, 0, 0, 0, 0);
        add_row(42, 21, 0, 0, 0, 0);
        add_row(21, 42, 0, 0, 0, 0);
        add_row(62,  0, 0, 0, 0, 0);
        add_row(63,  1, 0, 0, 0, 0);
        add_row(32, 33, 0, 0, 0, 0);
        add_row( 0, 62, 0, 0, 0, 0);
        add_row( 1, 63, 0, 0, 0, 0);

        // reset, then the clearing pass holds off the first transfer
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_q[i]) begin
            row = directed_q[i];
            push_site(row.site, row.typed, row.want);
        end

        // random part in four idling phases, runs on until the walk hits bottom
        n = 0;
        while (n < RAND_SITES || !walk_reached) begin
            case ((n * 4) / RAND_SITES)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 67; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 67; end
                default: begin send_idle_pct = 26; stall_pct = 26; end
            endcase
            push_site(next_site(), 1'b0, none);
            n++;
        end
        in_valid <= 1'b0;

        while (status_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d sites sent, %0d distinct opened, %0d results checked",
            sites_sent, open_count, results_seen);
        $display("top to bottom path %s", perc_seen ? "reached" : "not reached");
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/psl_pkg.sv
hdl/psl_label_ram.sv
hdl/psl_label_cmp.sv
hdl/percolation_site_labeler.sv
hdl/psl_checker.sv
test/tb_top.sv
